### design/ippb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ippb_pkg
// Shared types, constants and helpers for the pitch balance block.
// ----------------------------------------------------------------------------
package ippb_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_WIDTH_DEF  = 16;

  localparam int SQRT_ITERS   = 29;
  localparam int STEP_W       = 5;
  localparam int ATAN_ENTRIES = 24;

  localparam int PROD_W = 32;   // 16x16 products
  localparam int SUM_W  = 34;   // atan2 operands before rotation
  localparam int S_W    = 30;   // clamped asin argument
  localparam int ROOT_W = 58;   // square root working width
  localparam int ROOT_OUT_W = 29;
  localparam int CORD_W = 38;   // rotation x and y
  localparam int Q13_W  = 18;   // angle after conversion to q3.13

  localparam logic signed [15:0] PROP_GAIN_RST   = 16'sd942;
  localparam logic signed [15:0] DERIV_GAIN_RST  = 16'sd819;
  localparam logic signed [15:0] TARGET_PITCH_RST = 16'sd0;
  localparam logic [7:0]         RATE_DIVIDER_RST = 8'd5;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic signed [Q13_W-1:0] PI_Q13      = 18'sd25736;
  localparam logic signed [Q13_W-1:0] HALF_PI_Q13 = 18'sd12868;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [SUM_W-1:0] ONE_Q28 = 34'sd268435456;
  localparam logic signed [23:0] EFF_MAX = 24'sd8388607;
  localparam logic signed [23:0] EFF_MIN = -24'sd8388608;

  localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
    64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
    64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
    64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
    64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767,
    64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047,
    64'sd1023,      64'sd511,       64'sd255,       64'sd127
  };

  // q30 angle rounded half up to q3.(aw-3)
  function automatic longint to_angle(input longint q30, input int aw);
    return (q30 + (64'sd1 <<< (32 - aw))) >>> (33 - aw);
  endfunction

  typedef enum logic [1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_DERIV_GAIN   = 2'd1,
    REG_TARGET_PITCH = 2'd2,
    REG_RATE_DIVIDER = 2'd3
  } ippb_reg_t;

  typedef enum logic [1:0] {
    SEL_ROLL  = 2'd0,
    SEL_YAW   = 2'd1,
    SEL_PITCH = 2'd2
  } ippb_sel_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_PROD  = 11'b00000000010,
    ST_SUM   = 11'b00000000100,
    ST_SQ    = 11'b00000001000,
    ST_ROOT  = 11'b00000010000,
    ST_CINIT = 11'b00000100000,
    ST_CITER = 11'b00001000000,
    ST_CFIN  = 11'b00010000000,
    ST_TICK  = 11'b00100000000,
    ST_PDMUL = 11'b01000000000,
    ST_PDSUM = 11'b10000000000
  } ippb_state_t;

  typedef struct packed {
    logic              load;
    logic              prod;
    logic              sum;
    logic              square;
    logic              root;
    logic              c_init;
    logic              c_step;
    logic              c_fin;
    logic              tick;
    logic              pd_mul;
    logic              pd_sum;
    ippb_sel_t         sel;
    logic [STEP_W-1:0] step;
  } ippb_cmd_t;

  typedef struct packed {
    logic fire;
  } ippb_stat_t;

endpackage

### design/ippb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ippb_dp
// Datapath: quaternion products, square root, shared cordic, pd step.
// ----------------------------------------------------------------------------
module ippb_dp import ippb_pkg::*; #(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ippb_cmd_t          cmd,
  output ippb_stat_t         stat,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] prop_gain,
  input  logic signed [15:0] deriv_gain,
  input  logic signed [15:0] target_pitch,
  input  logic [7:0]         rate_divider,
  output logic signed [15:0] roll_store,
  output logic signed [15:0] pitch_store,
  output logic signed [15:0] yaw_store,
  output logic signed [23:0] effort_hold,
  output logic               effort_valid
);

  localparam int AZ = ANGLE_WIDTH + 1;
  localparam logic signed [AZ-1:0] HALF_A = AZ'(to_angle(HALF_PI_Q30, ANGLE_WIDTH));
  localparam logic [ROOT_W-1:0] ONE_SQ = ROOT_W'(1) << 56;

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [PROD_W-1:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  logic signed [SUM_W-1:0] roll_y, roll_x, yaw_y, yaw_x, s_raw;
  logic signed [S_W-1:0] s_val;
  logic signed [2*S_W-1:0] s_sq;
  logic [ROOT_W-1:0] rn, rres, rbit, trial;
  logic signed [CORD_W-1:0] cx, cy, xi, yi, dx, dy;
  logic signed [AZ-1:0] cz, step_ang;
  logic czero;
  logic signed [Q13_W-1:0] z_q13, ang;
  logic signed [17:0] previous_error, prev_e, diff;
  logic signed [16:0] err;
  logic first_step;
  logic [7:0] tick_count, tick_next;
  logic signed [32:0] pd_p;
  logic signed [33:0] pd_d;
  logic signed [35:0] pd_sum, pd_q, pd_neg;

  // square root and angle operand selection
  assign s_raw = (SUM_W'(p_wy) - SUM_W'(p_zx)) <<< 1;
  assign s_sq  = s_val * s_val;
  assign trial = rres + rbit;

  always_comb begin
    unique case (cmd.sel)
      SEL_ROLL: begin
        yi = CORD_W'(roll_y);
        xi = CORD_W'(roll_x);
      end
      SEL_YAW: begin
        yi = CORD_W'(yaw_y);
        xi = CORD_W'(yaw_x);
      end
      default: begin
        yi = CORD_W'(s_val);
        xi = CORD_W'(rres[ROOT_OUT_W-1:0]);
      end
    endcase
  end

  assign dx = cy >>> cmd.step;
  assign dy = cx >>> cmd.step;

  always_comb begin
    step_ang = '0;
    if (cmd.step < STEP_W'(ATAN_ENTRIES)) begin
      step_ang = AZ'(to_angle(ATAN_Q30[cmd.step], ANGLE_WIDTH));
    end
  end

  generate
    if (ANGLE_WIDTH > 16) begin : g_round
      localparam int SH = ANGLE_WIDTH - 16;
      logic signed [AZ:0] z_rnd;
      assign z_rnd = (AZ+1)'(cz) + (AZ+1)'(64'sd1 <<< (SH - 1));
      assign z_q13 = Q13_W'(z_rnd >>> SH);
    end else if (ANGLE_WIDTH == 16) begin : g_same
      assign z_q13 = Q13_W'(cz);
    end else begin : g_widen
      assign z_q13 = Q13_W'(cz) <<< (16 - ANGLE_WIDTH);
    end
  endgenerate

  always_comb begin
    ang = z_q13;
    if (ang > PI_Q13) begin
      ang = PI_Q13;
    end else if (ang < -PI_Q13) begin
      ang = -PI_Q13;
    end
    if (cmd.sel == SEL_PITCH) begin
      if (ang > HALF_PI_Q13) begin
        ang = HALF_PI_Q13;
      end else if (ang < -HALF_PI_Q13) begin
        ang = -HALF_PI_Q13;
      end
    end
    if (czero) begin
      ang = '0;
    end
  end

  // pd step
  assign tick_next = tick_count + 8'd1;
  assign stat.fire = (tick_next >= rate_divider);
  assign err    = 17'(target_pitch) - 17'(pitch_store);
  assign prev_e = first_step ? 18'(err) : previous_error;
  assign diff   = 18'(err) - prev_e;
  assign pd_sum = 36'(pd_p) + 36'(pd_d) + 36'sd2048;
  assign pd_q   = pd_sum >>> 12;
  assign pd_neg = -pd_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qw <= quat_w;
      qx <= quat_x;
      qy <= quat_y;
      qz <= quat_z;
    end
    if (cmd.prod) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
    end
    if (cmd.sum) begin
      roll_y <= (SUM_W'(p_wx) + SUM_W'(p_yz)) <<< 1;
      roll_x <= ONE_Q28 - ((SUM_W'(p_xx) + SUM_W'(p_yy)) <<< 1);
      yaw_y  <= (SUM_W'(p_wz) + SUM_W'(p_xy)) <<< 1;
      yaw_x  <= ONE_Q28 - ((SUM_W'(p_yy) + SUM_W'(p_zz)) <<< 1);
      if (s_raw > ONE_Q28) begin
        s_val <= S_W'(ONE_Q28);
      end else if (s_raw < -ONE_Q28) begin
        s_val <= S_W'(-ONE_Q28);
      end else begin
        s_val <= S_W'(s_raw);
      end
    end
    if (cmd.square) begin
      rn   <= ONE_SQ - ROOT_W'(s_sq);
      rres <= '0;
      rbit <= ONE_SQ;
    end
    if (cmd.root) begin
      if (rn >= trial) begin
        rn   <= rn - trial;
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (cmd.c_init) begin
      czero <= (xi == '0) && (yi == '0);
      if (xi < 0) begin
        if (yi >= 0) begin
          cx <= yi;
          cy <= -xi;
          cz <= HALF_A;
        end else begin
          cx <= -yi;
          cy <= xi;
          cz <= -HALF_A;
        end
      end else begin
        cx <= xi;
        cy <= yi;
        cz <= '0;
      end
    end
    if (cmd.c_step) begin
      if (cy >= 0) begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + step_ang;
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - step_ang;
      end
    end
    if (cmd.pd_mul) begin
      pd_p <= prop_gain * err;
      pd_d <= deriv_gain * diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_store     <= '0;
      pitch_store    <= '0;
      yaw_store      <= '0;
      previous_error <= '0;
      first_step     <= 1'b1;
      tick_count     <= '0;
      effort_hold    <= '0;
      effort_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        effort_valid <= 1'b0;
      end
      if (cmd.c_fin) begin
        unique case (cmd.sel)
          SEL_ROLL:  roll_store  <= 16'(ang);
          SEL_YAW:   yaw_store   <= 16'(ang);
          default:   pitch_store <= 16'(ang);
        endcase
      end
      if (cmd.tick) begin
        tick_count   <= stat.fire ? 8'd0 : tick_next;
        effort_valid <= stat.fire;
      end
      if (cmd.pd_mul) begin
        previous_error <= 18'(err);
        first_step     <= 1'b0;
      end
      if (cmd.pd_sum) begin
        if (pd_neg > 36'(EFF_MAX)) begin
          effort_hold <= EFF_MAX;
        end else if (pd_neg < 36'(EFF_MIN)) begin
          effort_hold <= EFF_MIN;
        end else begin
          effort_hold <= 24'(pd_neg);
        end
      end
    end
  end

endmodule

### design/ippb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ippb_ctrl
// Sequencer for quaternion conversion and the pd control step.
// ----------------------------------------------------------------------------
module ippb_ctrl import ippb_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic       slot_free,
  output logic       emit,
  input  ippb_stat_t stat,
  output ippb_cmd_t  cmd
);

  ippb_state_t       state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  ippb_sel_t         sel, sel_next;
  logic              done, done_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sel_next   = sel;
    done_next  = done;
    cmd        = '0;
    cmd.sel    = sel;
    cmd.step   = cnt;
    in_ready   = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (done) begin
          if (slot_free) begin
            emit      = 1'b1;
            done_next = 1'b0;
          end
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = (operation == OP_TICK) ? ST_TICK : ST_PROD;
          end
        end
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        cnt_next   = '0;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root = 1'b1;
        if (cnt == STEP_W'(SQRT_ITERS - 1)) begin
          cnt_next   = '0;
          sel_next   = SEL_ROLL;
          state_next = ST_CINIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_CINIT: begin
        cmd.c_init = 1'b1;
        cnt_next   = '0;
        state_next = ST_CITER;
      end
      ST_CITER: begin
        cmd.c_step = 1'b1;
        if (cnt == STEP_W'(CORDIC_STEPS - 1)) begin
          state_next = ST_CFIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_CFIN: begin
        cmd.c_fin = 1'b1;
        unique case (sel)
          SEL_ROLL: begin
            sel_next   = SEL_YAW;
            state_next = ST_CINIT;
          end
          SEL_YAW: begin
            sel_next   = SEL_PITCH;
            state_next = ST_CINIT;
          end
          default: begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_TICK: begin
        cmd.tick = 1'b1;
        if (stat.fire) begin
          state_next = ST_PDMUL;
        end else begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_PDMUL: begin
        cmd.pd_mul = 1'b1;
        state_next = ST_PDSUM;
      end
      ST_PDSUM: begin
        cmd.pd_sum = 1'b1;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      sel   <= SEL_ROLL;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
      done  <= done_next;
    end
  end

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_SAMPLE)) |=> (state == ST_PROD))
    else $error("sample item did not start the product stage");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (slot_free && done))
    else $error("result emitted without a free output slot");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    done |-> !in_ready)
    else $error("item accepted while a result is pending");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CITER) |-> (cnt < STEP_W'(CORDIC_STEPS)))
    else $error("rotation step count out of range");

endmodule

### design/imu_pitch_pd_balance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_pitch_pd_balance
// Quaternion to roll/pitch/yaw conversion with a pitch balance pd loop.
// ----------------------------------------------------------------------------
// A sample item (operation 0) runs from accept to result through the product,
// sum and square states, the bit-pair square root, then one shared cordic
// unit run three times (roll, yaw, pitch), each CORDIC_STEPS rotations plus
// setup and finish. A tick item advances the rate divider and, when it fires,
// runs a control step (one multiply and one add stage). One item is in work
// at a time; the result sits in an output register, so a new item is taken
// while it waits unless a finished result is still held back behind it.
module imu_pitch_pd_balance import ippb_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic signed [14:0] monitor_pitch,
  output logic               effort_valid,
  output logic signed [23:0] effort_cmd
);

  logic signed [15:0] prop_gain, deriv_gain, target_pitch;
  logic [7:0]         rate_divider;
  ippb_reg_t          reg_sel;
  logic               slot_free, emit;
  ippb_cmd_t          cmd;
  ippb_stat_t         stat;
  logic signed [15:0] roll_store, pitch_store, yaw_store;
  logic signed [23:0] effort_hold;
  logic               eff_valid;

  assign pready  = 1'b1;
  assign reg_sel = ippb_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= PROP_GAIN_RST;
      deriv_gain   <= DERIV_GAIN_RST;
      target_pitch <= TARGET_PITCH_RST;
      rate_divider <= RATE_DIVIDER_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_PROP_GAIN:    prop_gain    <= pwdata[15:0];
        REG_DERIV_GAIN:   deriv_gain   <= pwdata[15:0];
        REG_TARGET_PITCH: target_pitch <= pwdata[15:0];
        default:          rate_divider <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PROP_GAIN:    prdata = {16'd0, prop_gain};
      REG_DERIV_GAIN:   prdata = {16'd0, deriv_gain};
      REG_TARGET_PITCH: prdata = {16'd0, target_pitch};
      default:          prdata = {24'd0, rate_divider};
    endcase
  end

  assign slot_free = !out_valid || out_ready;

  ippb_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .operation(operation),
    .slot_free(slot_free),
    .emit     (emit),
    .stat     (stat),
    .cmd      (cmd)
  );

  ippb_dp #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .quat_w      (quat_w),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z),
    .prop_gain   (prop_gain),
    .deriv_gain  (deriv_gain),
    .target_pitch(target_pitch),
    .rate_divider(rate_divider),
    .roll_store  (roll_store),
    .pitch_store (pitch_store),
    .yaw_store   (yaw_store),
    .effort_hold (effort_hold),
    .effort_valid(eff_valid)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      roll_angle    <= roll_store;
      pitch_angle   <= pitch_store[14:0];
      yaw_angle     <= yaw_store;
      monitor_pitch <= 15'(-pitch_store);
      effort_valid  <= eff_valid;
      effort_cmd    <= effort_hold;
    end
  end

endmodule
